FILE: design/tod_pkg.sv
// Package with the shared types, widths and constants of the tilt orientation debouncer.
`timescale 1ns / 1ps

package tod_pkg;

   localparam int AccelWidth    = 16;
   localparam int TimeWidth     = 32;
   localparam int ThrWidth      = 15;
   localparam int DebWidth      = 16;
   localparam int LockWidth     = 8;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   typedef logic [1:0] rot_type;

   localparam rot_type ROT_0   = 2'd0;
   localparam rot_type ROT_90  = 2'd1;
   localparam rot_type ROT_180 = 2'd2;
   localparam rot_type ROT_270 = 2'd3;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_LOCK   = 2'd1,
      OP_UNLOCK = 2'd2,
      OP_INIT   = 2'd3
   } opcode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ENABLE         = 2'd0,
      CSR_TILT_THRESHOLD = 2'd1,
      CSR_FLAT_LIMIT     = 2'd2,
      CSR_DEBOUNCE_TIME  = 2'd3
   } csr_index_type;

   localparam logic                RESET_ENABLE   = 1'b1;
   localparam logic [ThrWidth-1:0] RESET_TILT     = 15'd2365;
   localparam logic [ThrWidth-1:0] RESET_FLAT     = 15'd2867;
   localparam logic [DebWidth-1:0] RESET_DEBOUNCE = 16'd500;
   localparam rot_type             RESET_ROTATION = ROT_90;

   typedef struct packed {
      logic                enable;
      logic [ThrWidth-1:0] tilt_threshold;
      logic [ThrWidth-1:0] flat_limit;
      logic [DebWidth-1:0] debounce_time;
   } cfg_type;

   typedef struct packed {
      rot_type              cur;
      rot_type              pend;
      logic [TimeWidth-1:0] since_ms;
      logic                 locked;
   } state_type;

   typedef struct packed {
      opcode_type                   opcode;
      logic signed [AccelWidth-1:0] accel_x;
      logic signed [AccelWidth-1:0] accel_y;
      logic signed [AccelWidth-1:0] accel_z;
      logic [TimeWidth-1:0]         now_ms;
      logic [LockWidth-1:0]         lock_value;
   } req_item_type;

   typedef struct packed {
      rot_type             rotation;
      logic                changed;
      logic [DebWidth-1:0] time_to_change;
   } rsp_item_type;

endpackage

FILE: design/tod_req_if.sv
// Request channel interface: opcode, acceleration sample, time stamp and lock value.
`timescale 1ns / 1ps

interface tod_req_if;
   import tod_pkg::*;

   logic                         valid;
   logic                         ready;
   opcode_type                   opcode;
   logic signed [AccelWidth-1:0] accel_x;
   logic signed [AccelWidth-1:0] accel_y;
   logic signed [AccelWidth-1:0] accel_z;
   logic [TimeWidth-1:0]         now_ms;
   logic [LockWidth-1:0]         lock_value;

   modport source (
      output valid, opcode, accel_x, accel_y, accel_z, now_ms, lock_value,
      input  ready
   );

   modport sink (
      input  valid, opcode, accel_x, accel_y, accel_z, now_ms, lock_value,
      output ready
   );
endinterface

FILE: design/tod_rsp_if.sv
// Response channel interface: rotation, change flag and time until change.
`timescale 1ns / 1ps

interface tod_rsp_if;
   import tod_pkg::*;

   logic                valid;
   logic                ready;
   rot_type             rotation;
   logic                changed;
   logic [DebWidth-1:0] time_to_change;

   modport source (
      output valid, rotation, changed, time_to_change,
      input  ready
   );

   modport sink (
      input  valid, rotation, changed, time_to_change,
      output ready
   );
endinterface

FILE: design/tod_detect.sv
// Rotation detection from one acceleration sample against the tilt and flat limits.
`timescale 1ns / 1ps

module tod_detect (
   input  logic signed [tod_pkg::AccelWidth-1:0] accel_x,
   input  logic signed [tod_pkg::AccelWidth-1:0] accel_y,
   input  logic signed [tod_pkg::AccelWidth-1:0] accel_z,
   input  tod_pkg::cfg_type                      cfg,
   input  tod_pkg::rot_type                      cur_rot,
   output tod_pkg::rot_type                      det_rot
);
   import tod_pkg::*;

   localparam int MagWidth = AccelWidth + 1;

   logic [MagWidth-1:0]        mag_x;
   logic [MagWidth-1:0]        mag_y;
   logic [MagWidth-1:0]        mag_z;
   logic signed [MagWidth-1:0] ext_x;
   logic signed [MagWidth-1:0] ext_y;
   logic signed [MagWidth-1:0] thr_pos;
   logic signed [MagWidth-1:0] thr_neg;

   // One extra bit so that the most negative input has a representable magnitude.
   function automatic logic [MagWidth-1:0] magnitude(input logic signed [AccelWidth-1:0] v);
      logic [MagWidth-1:0] e;
      begin
         e = {v[AccelWidth-1], v};
         return e[MagWidth-1] ? (~e + 1'b1) : e;
      end
   endfunction

   assign mag_x   = magnitude(accel_x);
   assign mag_y   = magnitude(accel_y);
   assign mag_z   = magnitude(accel_z);
   assign ext_x   = {accel_x[AccelWidth-1], accel_x};
   assign ext_y   = {accel_y[AccelWidth-1], accel_y};
   assign thr_pos = {{(MagWidth-ThrWidth){1'b0}}, cfg.tilt_threshold};
   assign thr_neg = -thr_pos;

   always_comb begin
      det_rot = cur_rot;
      if (mag_z <= {{(MagWidth-ThrWidth){1'b0}}, cfg.flat_limit}) begin
         if (mag_x > mag_y) begin
            if (ext_x > thr_pos) begin
               det_rot = ROT_90;
            end else if (ext_x < thr_neg) begin
               det_rot = ROT_270;
            end
         end else begin
            if (ext_y > thr_pos) begin
               det_rot = ROT_0;
            end else if (ext_y < thr_neg) begin
               det_rot = ROT_180;
            end
         end
      end
   end

endmodule

FILE: design/tod_update.sv
// Next-state and result logic for one item: debounce, lock, unlock and initialise.
`timescale 1ns / 1ps

module tod_update (
   input  tod_pkg::req_item_type item,
   input  tod_pkg::cfg_type      cfg,
   input  tod_pkg::state_type    state,
   input  tod_pkg::rot_type      det_rot,
   output tod_pkg::state_type    state_next,
   output tod_pkg::rsp_item_type result
);
   import tod_pkg::*;

   logic [TimeWidth-1:0] elapsed;
   logic [TimeWidth-1:0] elapsed_next;
   logic [TimeWidth-1:0] debounce_ext;
   logic                 restart;
   rot_type              lock_rot;

   assign elapsed      = item.now_ms - state.since_ms;
   assign debounce_ext = TimeWidth'(cfg.debounce_time);
   assign lock_rot     = (item.lock_value > LockWidth'(ROT_270)) ? ROT_270
                                                                   : item.lock_value[1:0];

   always_comb begin
      state_next     = state;
      restart        = 1'b0;
      result.changed = 1'b0;
      unique case (item.opcode)
         OP_SAMPLE: begin
            if (cfg.enable && !state.locked) begin
               if (det_rot != state.cur) begin
                  if (det_rot != state.pend) begin
                     state_next.pend     = det_rot;
                     state_next.since_ms = item.now_ms;
                     restart             = 1'b1;
                  end else if (elapsed >= debounce_ext) begin
                     state_next.cur = det_rot;
                     result.changed = 1'b1;
                  end
               end else begin
                  state_next.pend     = state.cur;
                  state_next.since_ms = item.now_ms;
                  restart             = 1'b1;
               end
            end
         end
         OP_LOCK: begin
            state_next.locked = 1'b1;
            state_next.cur    = lock_rot;
            state_next.pend   = lock_rot;
            result.changed    = 1'b1;
         end
         OP_UNLOCK: begin
            state_next.locked   = 1'b0;
            state_next.since_ms = item.now_ms;
            restart             = 1'b1;
         end
         OP_INIT: begin
            state_next.cur  = det_rot;
            state_next.pend = det_rot;
         end
      endcase

      // When the pending time restarts at this item, no time has elapsed.
      elapsed_next          = restart ? '0 : elapsed;
      result.rotation       = state_next.cur;
      result.time_to_change = '0;
      if ((state_next.pend != state_next.cur) && (elapsed_next < debounce_ext)) begin
         result.time_to_change = cfg.debounce_time - elapsed_next[DebWidth-1:0];
      end
   end

endmodule

FILE: design/tilt_orientation_debouncer.sv
// Top level of the tilt orientation debouncer: registers, handshake and checks.
`timescale 1ns / 1ps

// The block turns accelerometer samples into a debounced screen rotation (0 to 3).
// It takes one request transfer per clock cycle while responses are taken and
// returns exactly one response transfer for each, in order; a request is held in
// the input register and its response is written to the output register when the
// input stage advances. The rate is one item per cycle because all detection and
// state update happens in one pass between the input register and the output
// register, and the rotation state is written at the same edge as the response,
// ready for the following item. The input register keeps taking transfers while a
// finished response waits, as long as that response is taken in the same cycle;
// when the response side stalls, one more item is held in the input register and
// the request side then stalls too. Configuration registers (enable, tilt
// threshold, flat limit, debounce time) are written through the csr port, one
// register per cycle at csr_index, and must only be changed while no transfer is
// in flight.

module tilt_orientation_debouncer (
   input  logic                                clock,
   input  logic                                reset,
   tod_req_if.sink                             req_chan,
   tod_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [tod_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tod_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import tod_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   state_type    state_ff;
   cfg_type      cfg_ff;

   req_item_type req_item;
   state_type    state_next;
   rsp_item_type result;
   rot_type      det_rot;
   logic         s1_advance;
   logic         req_take;

   // The input stage moves on when the output register is empty or is being emptied.
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign req_item.opcode     = req_chan.opcode;
   assign req_item.accel_x    = req_chan.accel_x;
   assign req_item.accel_y    = req_chan.accel_y;
   assign req_item.accel_z    = req_chan.accel_z;
   assign req_item.now_ms     = req_chan.now_ms;
   assign req_item.lock_value = req_chan.lock_value;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Detection always compares against the rotation in force before this item.
   tod_detect u_detect (
      .accel_x (s1_item_ff.accel_x),
      .accel_y (s1_item_ff.accel_y),
      .accel_z (s1_item_ff.accel_z),
      .cfg     (cfg_ff),
      .cur_rot (state_ff.cur),
      .det_rot (det_rot)
   );

   tod_update u_update (
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .det_rot    (det_rot),
      .state_next (state_next),
      .result     (result)
   );

   // Control state, rotation state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff.cur          <= RESET_ROTATION;
         state_ff.pend         <= RESET_ROTATION;
         state_ff.since_ms     <= '0;
         state_ff.locked       <= 1'b0;
         cfg_ff.enable         <= RESET_ENABLE;
         cfg_ff.tilt_threshold <= RESET_TILT;
         cfg_ff.flat_limit     <= RESET_FLAT;
         cfg_ff.debounce_time  <= RESET_DEBOUNCE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff <= state_next;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENABLE:         cfg_ff.enable         <= csr_wdata[0];
               CSR_TILT_THRESHOLD: cfg_ff.tilt_threshold <= csr_wdata[ThrWidth-1:0];
               CSR_FLAT_LIMIT:     cfg_ff.flat_limit     <= csr_wdata[ThrWidth-1:0];
               CSR_DEBOUNCE_TIME:  cfg_ff.debounce_time  <= csr_wdata[DebWidth-1:0];
               default:            ;
            endcase
         end
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.rotation       = rsp_item_ff.rotation;
   assign rsp_chan.changed        = rsp_item_ff.changed;
   assign rsp_chan.time_to_change = rsp_item_ff.time_to_change;

   // A change of rotation always leaves nothing pending, so no countdown is reported.
   a_changed_no_countdown: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.changed |-> rsp_chan.time_to_change == '0)
      else $error("changed response reports a nonzero time to change");

   // While locked, only a lock or an initialise may move the current rotation.
   a_locked_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff.locked && !(s1_advance && (s1_item_ff.opcode == OP_LOCK ||
                                          s1_item_ff.opcode == OP_INIT))
      |=> $stable(state_ff.cur))
      else $error("current rotation moved while locked");

   // A lock leaves the block locked and presents a changed response.
   a_lock_effect: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_item_ff.opcode == OP_LOCK
      |=> state_ff.locked && rsp_chan.valid && rsp_chan.changed)
      else $error("lock did not take effect");

endmodule
